FILE: src/bhs_pkg.sv
package bhs_pkg;

    // Width of the shared settle/timeout counter
    localparam int DELAY_BITS = 16;
    localparam int CFG_BITS   = 16;

    localparam logic [CFG_BITS-1:0] SETTLE_DELAY_RESET = CFG_BITS'(25);

    typedef enum logic [2:0] {
        ST_WAIT_BALL  = 3'd0,
        ST_OPEN_GATE  = 3'd1,
        ST_HOLD       = 3'd2,
        ST_PUSH       = 3'd3,
        ST_CLOSE_GATE = 3'd4,
        ST_REMOVE     = 3'd5,
        ST_ERROR      = 3'd6
    } t_state;

    typedef enum logic [2:0] {
        CMD_NONE   = 3'd0,
        CMD_CLOSE  = 3'd1,
        CMD_OPEN   = 3'd2,
        CMD_HOLD   = 3'd3,
        CMD_PUSH   = 3'd4,
        CMD_REMOVE = 3'd5
    } t_cmd;

    typedef struct packed {
        logic ball_present;
        logic gate_open;
        logic gate_closed;
        logic push_request;
    } t_in_beat;

    typedef struct packed {
        t_cmd   actuator_cmd;
        t_state phase;
    } t_out_beat;

    typedef struct packed {
        logic                  running;
        logic [DELAY_BITS-1:0] remaining;
    } t_timer;

endpackage

FILE: src/bhs_step.sv
module bhs_step (
    input  bhs_pkg::t_state                  i_state,
    input  bhs_pkg::t_timer                  i_timer,
    input  bhs_pkg::t_in_beat                i_in,
    input  logic [bhs_pkg::CFG_BITS-1:0]     i_settle_delay,
    output bhs_pkg::t_state                  o_next_state,
    output bhs_pkg::t_timer                  o_next_timer,
    output bhs_pkg::t_cmd                    o_cmd
);
    import bhs_pkg::*;

    localparam int WIDE_BITS = (DELAY_BITS > CFG_BITS) ? DELAY_BITS + 1 : CFG_BITS + 1;
    localparam logic [DELAY_BITS-1:0] CNT_MAX = '1;

    logic [DELAY_BITS-1:0] dec_count;
    logic [DELAY_BITS-1:0] load_count;
    logic [WIDE_BITS-1:0]  wide_cfg;
    logic                  expired;

    // Count down a running timer before the state looks at it
    always_comb begin
        if (i_timer.running && (i_timer.remaining != '0)) begin
            dec_count = i_timer.remaining - DELAY_BITS'(1);
        end else begin
            dec_count = i_timer.remaining;
        end
        expired = i_timer.running && (dec_count == '0);
    end

    // Saturate the register value into the counter
    always_comb begin
        wide_cfg = WIDE_BITS'(i_settle_delay);
        if (wide_cfg > WIDE_BITS'(CNT_MAX)) begin
            load_count = CNT_MAX;
        end else begin
            load_count = wide_cfg[DELAY_BITS-1:0];
        end
    end

    // Next state and timer
    always_comb begin
        o_next_state           = i_state;
        o_next_timer.running   = i_timer.running;
        o_next_timer.remaining = dec_count;
        case (i_state)
            ST_WAIT_BALL: begin
                if (i_in.ball_present) begin
                    if (!i_timer.running) begin
                        o_next_timer.running   = 1'b1;
                        o_next_timer.remaining = load_count;
                    end else if (expired) begin
                        o_next_timer.running = 1'b0;
                        o_next_state         = ST_OPEN_GATE;
                    end
                end
            end
            ST_OPEN_GATE: begin
                if (i_in.gate_open) begin
                    o_next_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (!i_in.ball_present) begin
                    o_next_state = ST_WAIT_BALL;
                end else if (i_in.push_request) begin
                    o_next_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                if (!i_timer.running) begin
                    o_next_timer.running   = 1'b1;
                    o_next_timer.remaining = load_count;
                end else if (expired) begin
                    o_next_timer.running = 1'b0;
                    o_next_state = i_in.ball_present ? ST_REMOVE : ST_CLOSE_GATE;
                end
            end
            ST_CLOSE_GATE: begin
                if (i_in.gate_closed) begin
                    o_next_state = ST_WAIT_BALL;
                end
            end
            ST_REMOVE: begin
                if (!i_timer.running) begin
                    o_next_timer.running   = 1'b1;
                    o_next_timer.remaining = load_count;
                end else if (expired) begin
                    o_next_timer.running = 1'b0;
                    o_next_state = i_in.ball_present ? ST_ERROR : ST_CLOSE_GATE;
                end
            end
            ST_ERROR: begin
                if (!i_in.ball_present && i_in.gate_closed) begin
                    o_next_state = ST_WAIT_BALL;
                end
            end
            default: begin
                o_next_state = ST_WAIT_BALL;
            end
        endcase
    end

    // Actuator command of the state acted in
    always_comb begin
        case (i_state)
            ST_WAIT_BALL:  o_cmd = CMD_CLOSE;
            ST_OPEN_GATE:  o_cmd = CMD_OPEN;
            ST_HOLD:       o_cmd = i_in.ball_present ? CMD_HOLD : CMD_NONE;
            ST_PUSH:       o_cmd = CMD_PUSH;
            ST_CLOSE_GATE: o_cmd = CMD_CLOSE;
            ST_REMOVE:     o_cmd = CMD_REMOVE;
            ST_ERROR:      o_cmd = CMD_CLOSE;
            default:       o_cmd = CMD_NONE;
        endcase
    end

endmodule

FILE: src/ball_holder_sequencer.sv
// Ball holder sequencer: one input beat is one control tick of four sensor flags,
// and each tick yields exactly one result beat with the actuator command of the
// state acted in and the state after the tick. A beat is registered on entry,
// stepped through the sequencer on its way into the output register, and
// leaves from there; one tick is taken every cycle while i_out_stall does not
// hold the output register, the step from input register to output register
// being combinational. The settle, push and removal timeouts share one timer
// loaded from r_settle_delay and counted in ticks, so the delay seen in
// time is that value times the tick period. Write the register only while no
// beat is in flight.
module ball_holder_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  bhs_pkg::t_in_beat             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output bhs_pkg::t_out_beat            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [bhs_pkg::CFG_BITS-1:0]  i_cfg_data
);
    import bhs_pkg::*;

    logic [CFG_BITS-1:0] r_settle_delay;
    logic                r_in_valid;
    t_in_beat            r_in_data;
    logic                r_out_valid;
    t_out_beat           r_out_data;
    t_state              r_state;
    t_timer              r_timer;

    t_state              n_state;
    t_timer              n_timer;
    t_cmd                step_cmd;
    logic                advance;
    logic                accept;

    // Stage 1 moves on whenever the output register is empty or being drained
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    bhs_step u_step (
        .i_state        (r_state),
        .i_timer        (r_timer),
        .i_in           (r_in_data),
        .i_settle_delay (r_settle_delay),
        .o_next_state   (n_state),
        .o_next_timer   (n_timer),
        .o_cmd          (step_cmd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_delay <= SETTLE_DELAY_RESET;
        end else if (i_cfg_we) begin
            r_settle_delay <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_data <= i_in_data;
        end
    end

    // Step the sequencer only as a beat enters the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_WAIT_BALL;
            r_timer.running <= 1'b0;
            r_timer.remaining <= '0;
            r_out_valid     <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
                r_timer <= n_timer;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_data.actuator_cmd <= step_cmd;
            r_out_data.phase        <= n_state;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bhs_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    // Sequencer predictor plus the queue of beats still owed by the block
    class tick_scoreboard;
        t_state           seq_state;
        logic [15:0]      delay_left;
        bit               delay_on;
        logic [15:0]      settle_ticks;
        t_out_beat        owed_q[$];
        int               mismatches;
        int               ticks_taken;
        int               beats_checked;
        bit [6:0]         states_seen;

        function new();
            seq_state     = ST_WAIT_BALL;
            delay_left    = '0;
            delay_on      = 1'b0;
            settle_ticks  = SETTLE_DELAY_RESET;
            mismatches    = 0;
            ticks_taken   = 0;
            beats_checked = 0;
            states_seen   = 7'b1;
        endfunction

        function void set_delay(logic [15:0] v);
            settle_ticks = v;
        endfunction

        function void arm();
            delay_left = settle_ticks;
            delay_on   = 1'b1;
        endfunction

        // Report expiry once and drop the running flag
        function bit expire();
            if (delay_on && delay_left == 0) begin
                delay_on = 1'b0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_tick(t_in_beat b);
            t_out_beat r;
            t_cmd      cmd;
            t_state    nxt;
            cmd = CMD_NONE;
            nxt = seq_state;
            if (delay_on && delay_left != 0) delay_left = delay_left - 16'd1;
            case (seq_state)
                ST_WAIT_BALL: begin
                    cmd = CMD_CLOSE;
                    if (b.ball_present) begin
                        if (!delay_on) arm();
                        else if (expire()) nxt = ST_OPEN_GATE;
                    end
                end
                ST_OPEN_GATE: begin
                    cmd = CMD_OPEN;
                    if (b.gate_open) nxt = ST_HOLD;
                end
                ST_HOLD: begin
                    if (!b.ball_present) begin
                        nxt = ST_WAIT_BALL;
                    end else begin
                        cmd = CMD_HOLD;
                        if (b.push_request) nxt = ST_PUSH;
                    end
                end
                ST_PUSH: begin
                    cmd = CMD_PUSH;
                    if (!delay_on) arm();
                    else if (expire()) nxt = b.ball_present ? ST_REMOVE : ST_CLOSE_GATE;
                end
                ST_CLOSE_GATE: begin
                    cmd = CMD_CLOSE;
                    if (b.gate_closed) nxt = ST_WAIT_BALL;
                end
                ST_REMOVE: begin
                    cmd = CMD_REMOVE;
                    if (!delay_on) arm();
                    else if (expire()) nxt = b.ball_present ? ST_ERROR : ST_CLOSE_GATE;
                end
                ST_ERROR: begin
                    cmd = CMD_CLOSE;
                    if (!b.ball_present && b.gate_closed) nxt = ST_WAIT_BALL;
                end
                default: nxt = ST_WAIT_BALL;
            endcase
            seq_state = nxt;
            states_seen[nxt] = 1'b1;
            ticks_taken++;
            r.actuator_cmd = cmd;
            r.phase        = nxt;
            owed_q.push_back(r);
        endfunction

        function void check_beat(t_out_beat got);
            t_out_beat exp_beat;
            if (owed_q.size() == 0) begin
                $display("%0t: unexpected beat cmd %0d phase %0d", $realtime,
                         got.actuator_cmd, got.phase);
                mismatches++;
                return;
            end
            exp_beat = owed_q.pop_front();
            beats_checked++;
            if (got.actuator_cmd !== exp_beat.actuator_cmd) begin
                $display("%0t: actuator_cmd expected %0d actual %0d", $realtime,
                         exp_beat.actuator_cmd, got.actuator_cmd);
                mismatches++;
            end
            if (got.phase !== exp_beat.phase) begin
                $display("%0t: phase expected %0d actual %0d", $realtime,
                         exp_beat.phase, got.phase);
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    t_in_beat    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_beat   o_out_data;
    logic        i_cfg_we = 1'b0;
    logic [CFG_BITS-1:0] i_cfg_data = '0;

    tick_scoreboard sb = new();

    bit          quiet_in = 1'b0;
    bit          quiet_out = 1'b0;
    bit          long_hold_req = 1'b0;
    int unsigned cycle_count = 0;
    int          long_stalls_seen = 0;

    ball_holder_sequencer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_in_valid && o_in_stall) long_stalls_seen <= long_stalls_seen + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d beats outstanding", $realtime,
                     sb.owed_q.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Output side: random back-pressure, one long hold-off on request
    initial begin : result_sink
        int hold;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                hold = 60;
                long_hold_req = 1'b0;
            end else begin
                hold = quiet_out ? 0 : $urandom_range(0, 5);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_beat(o_out_data);
        end
    end

    task automatic send_tick(input t_in_beat b);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_tick(b);
    endtask

    // Drain all owed beats, let the pipeline settle, then write the delay
    task automatic write_delay(input logic [15:0] v);
        i_in_valid <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_delay(v);
    endtask

    // Mostly flags that move the current state on, some pure noise
    function automatic t_in_beat pick_tick();
        t_in_beat b;
        b = t_in_beat'(4'($urandom_range(0, 15)));
        if ($urandom_range(0, 3) != 0) begin
            case (sb.seq_state)
                ST_WAIT_BALL: b.ball_present = ($urandom_range(0, 4) != 0);
                ST_HOLD:      b.ball_present = ($urandom_range(0, 7) != 0);
                ST_ERROR: begin
                    if ($urandom_range(0, 1) != 0) begin
                        b.ball_present = 1'b0;
                        b.gate_closed  = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        return b;
    endfunction

    task automatic run_random(input int n);
        repeat (n) send_tick(pick_tick());
    endtask

    initial begin : main_seq
        t_in_beat directed_ticks[24];
        directed_ticks = '{
            4'b0000, 4'b1000, 4'b0000, 4'b1000, 4'b1011, 4'b0100,
            4'b1001, 4'b1000, 4'b1000, 4'b1111, 4'b1111, 4'b1111,
            4'b0010, 4'b1000, 4'b1000, 4'b0100, 4'b0000, 4'b1000,
            4'b1000, 4'b1100, 4'b1001, 4'b1000, 4'b0000, 4'b0010
        };
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset delay value
        run_random(100);

        // one-tick delay: walk every state, ball leaving mid-settle
        write_delay(16'd1);
        foreach (directed_ticks[k]) send_tick(directed_ticks[k]);
        run_random(150);

        // zero delay expires on the next tick; fill the block meanwhile
        write_delay(16'd0);
        long_hold_req = 1'b1;
        quiet_in = 1'b1;
        run_random(80);
        quiet_in = 1'b0;
        run_random(70);

        write_delay(16'd3);
        quiet_in  = 1'b1;
        quiet_out = 1'b1;
        run_random(100);
        quiet_in  = 1'b0;
        quiet_out = 1'b0;
        run_random(100);

        write_delay(16'd7);
        run_random(150);

        write_delay(16'd2);
        run_random(150);

        // largest delay last: a long-running timer would stall later phases
        write_delay(16'hFFFF);
        run_random(40);

        i_in_valid <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d ticks and %0d checked beats over seven delay settings.",
                 sb.ticks_taken, sb.beats_checked);
        $display("States reached mask %b, %0d cycles with input held back.",
                 sb.states_seen, long_stalls_seen);
        if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
